>>> src/ultrasonic_collision_warning_core_macros.svh
// Assertion macros for the ultrasonic collision warning core.
// Used by the checker; depends on nothing else.
`ifndef ULTRASONIC_COLLISION_WARNING_CORE_MACROS_SVH
`define ULTRASONIC_COLLISION_WARNING_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define UCW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ucw assertion failed");

// Next-cycle implication, disabled during reset.
`define UCW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ucw assertion failed");

`endif

>>> src/ucw_pkg.sv
// Shared types and constants for the ultrasonic collision warning core.
// No dependencies; imported by every RTL module of the block.
`default_nettype none

package ucw_pkg;

	localparam int NUM_SLOTS  = 6;
	localparam int DIST_W     = 14;
	localparam int CFG_W      = 16;
	localparam int LIMIT_W    = CFG_W + 1;
	localparam int ID_W       = 11;

	localparam logic [ID_W-1:0]   ID_NEAR    = 11'h611;
	localparam logic [ID_W-1:0]   ID_FAR     = 11'h612;
	localparam logic [DIST_W-1:0] DIST_RESET = 14'd9999;

	localparam logic [CFG_W-1:0] THRESH_RESET = 16'd50;
	localparam logic [CFG_W-1:0] FRONT_RESET  = 16'd100;
	localparam logic [CFG_W-1:0] RIGHT_RESET  = 16'd140;
	localparam logic [CFG_W-1:0] LEFT_RESET   = 16'd180;

	typedef logic [DIST_W-1:0]  dist_t;
	typedef dist_t [NUM_SLOTS-1:0] dist_vec_t;
	typedef logic [LIMIT_W-1:0] limit_t;

	typedef enum logic [1:0] {
		CFG_WARN_THRESHOLD = 2'd0,
		CFG_FRONT_MARGIN   = 2'd1,
		CFG_RIGHT_MARGIN   = 2'd2,
		CFG_LEFT_MARGIN    = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ZONE_NONE  = 2'd0,
		ZONE_FRONT = 2'd1,
		ZONE_RIGHT = 2'd2,
		ZONE_LEFT  = 2'd3
	} zone_t;

	typedef struct packed {
		logic [CFG_W-1:0] warn_threshold;
		logic [CFG_W-1:0] front_margin;
		logic [CFG_W-1:0] right_margin;
		logic [CFG_W-1:0] left_margin;
	} cfg_t;

	typedef struct packed {
		logic  stop;
		zone_t zone;
	} result_t;

endpackage

`default_nettype wire

>>> src/ultrasonic_collision_warning_core.sv
// Ultrasonic collision warning core. Each accepted item is one CAN frame;
// frames 0x611 and 0x612 refresh the six stored distances (sent as BCD), and every
// frame produces one result: stop_request plus the highest-priority zone
// (front, right, left) whose distance lies below threshold plus margin.
// The core takes one item per clock while the output is not stalled: an input
// register holds the frame, then decode, distance update and the six compares
// run combinationally into the result register. A stalled result only blocks
// input once both registers are full. Distances reset to 9999.
// Depends on ucw_pkg, ucw_bcd_decode and ucw_zone_eval.
`default_nettype none

module ultrasonic_collision_warning_core
	import ucw_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [ID_W-1:0]   frame_id,
	input  wire logic [7:0]        byte0,
	input  wire logic [7:0]        byte1,
	input  wire logic [7:0]        byte2,
	input  wire logic [7:0]        byte3,
	input  wire logic [7:0]        byte4,
	input  wire logic [7:0]        byte5,
	input  wire logic [7:0]        byte6,
	input  wire logic [7:0]        byte7,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic                   stop_request,
	output logic [1:0]             zone,
	input  wire logic              cfg_we,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [CFG_W-1:0]  cfg_data
);

	logic              valid_s1;
	logic [ID_W-1:0]   id_s1;
	logic [7:0]        bytes_s1 [8];
	logic              valid_s2;
	result_t           res_s2;
	dist_vec_t         dist_q;
	dist_vec_t         dist_next;
	dist_t             dec [4];
	cfg_t              cfg_q;
	result_t           res_next;
	logic              advance;

	assign advance  = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			id_s1       <= frame_id;
			bytes_s1[0] <= byte0;
			bytes_s1[1] <= byte1;
			bytes_s1[2] <= byte2;
			bytes_s1[3] <= byte3;
			bytes_s1[4] <= byte4;
			bytes_s1[5] <= byte5;
			bytes_s1[6] <= byte6;
			bytes_s1[7] <= byte7;
		end
	end

	for (genvar g = 0; g < 4; g++) begin : g_dec
		ucw_bcd_decode u_dec (
			.hi      (bytes_s1[2*g]),
			.lo      (bytes_s1[2*g+1]),
			.dist_mm (dec[g])
		);
	end

	// the first two distances of the far frame are dropped
	always_comb begin
		dist_next = dist_q;
		if (id_s1 == ID_NEAR) begin
			dist_next[0] = dec[0];
			dist_next[1] = dec[1];
			dist_next[2] = dec[2];
			dist_next[3] = dec[3];
		end else if (id_s1 == ID_FAR) begin
			dist_next[4] = dec[2];
			dist_next[5] = dec[3];
		end
	end

	ucw_zone_eval u_eval (
		.dists  (dist_next),
		.cfg    (cfg_q),
		.result (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_q <= {NUM_SLOTS{DIST_RESET}};
		end else if (valid_s1 && advance) begin
			dist_q <= dist_next;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			res_s2 <= res_next;
		end
	end

	assign out_valid    = valid_s2;
	assign stop_request = res_s2.stop;
	assign zone         = res_s2.zone;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.warn_threshold <= THRESH_RESET;
			cfg_q.front_margin   <= FRONT_RESET;
			cfg_q.right_margin   <= RIGHT_RESET;
			cfg_q.left_margin    <= LEFT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_WARN_THRESHOLD: cfg_q.warn_threshold <= cfg_data;
				CFG_FRONT_MARGIN:   cfg_q.front_margin   <= cfg_data;
				CFG_RIGHT_MARGIN:   cfg_q.right_margin   <= cfg_data;
				CFG_LEFT_MARGIN:    cfg_q.left_margin    <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> src/ucw_bcd_decode.sv
// Decodes one byte pair (four BCD digits, high byte first) into a distance.
// Depends on ucw_pkg.
`default_nettype none

module ucw_bcd_decode
	import ucw_pkg::*;
(
	input  wire logic [7:0] hi,
	input  wire logic [7:0] lo,
	output dist_t           dist_mm
);

	logic [3:0] n3, n2, n1, n0;
	logic       bad;
	dist_t      sum;

	assign n3 = hi[7:4];
	assign n2 = hi[3:0];
	assign n1 = lo[7:4];
	assign n0 = lo[3:0];

	// any nibble above nine makes the whole pair read as zero
	assign bad = (n3 > 4'd9) || (n2 > 4'd9) || (n1 > 4'd9) || (n0 > 4'd9);

	assign sum = DIST_W'(n3) * DIST_W'(1000) + DIST_W'(n2) * DIST_W'(100)
		+ DIST_W'(n1) * DIST_W'(10) + DIST_W'(n0);

	assign dist_mm = bad ? '0 : sum;

endmodule

`default_nettype wire

>>> src/ucw_zone_eval.sv
// Compares the six distances against per-zone limits and picks the zone.
// Depends on ucw_pkg.
`default_nettype none

module ucw_zone_eval
	import ucw_pkg::*;
(
	input  dist_vec_t dists,
	input  cfg_t      cfg,
	output result_t   result
);

	limit_t lim_front, lim_right, lim_left;
	logic   hit_front, hit_right, hit_left;

	assign lim_front = LIMIT_W'(cfg.warn_threshold) + LIMIT_W'(cfg.front_margin);
	assign lim_right = LIMIT_W'(cfg.warn_threshold) + LIMIT_W'(cfg.right_margin);
	assign lim_left  = LIMIT_W'(cfg.warn_threshold) + LIMIT_W'(cfg.left_margin);

	assign hit_front = (LIMIT_W'(dists[0]) < lim_front) || (LIMIT_W'(dists[1]) < lim_front);
	assign hit_right = (LIMIT_W'(dists[2]) < lim_right) || (LIMIT_W'(dists[3]) < lim_right);
	assign hit_left  = (LIMIT_W'(dists[4]) < lim_left)  || (LIMIT_W'(dists[5]) < lim_left);

	// front wins over right, right over left
	always_comb begin
		result.stop = 1'b1;
		if (hit_front) begin
			result.zone = ZONE_FRONT;
		end else if (hit_right) begin
			result.zone = ZONE_RIGHT;
		end else if (hit_left) begin
			result.zone = ZONE_LEFT;
		end else begin
			result.stop = 1'b0;
			result.zone = ZONE_NONE;
		end
	end

endmodule

`default_nettype wire

>>> src/ucw_checker.sv
// Port-level checker for the ultrasonic collision warning core, bound to it.
// Depends on ultrasonic_collision_warning_core_macros.svh.
`default_nettype none
`include "ultrasonic_collision_warning_core_macros.svh"

module ucw_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic       stop_request,
	input wire logic [1:0] zone
);

	// a result carries a zone exactly when it requests a stop
	`UCW_ASSERT_NOW(a_zone_matches_stop, clk, arst_n, out_valid, stop_request == (zone != 2'd0))

	// input backs up only while a result is waiting and the output stalls
	`UCW_ASSERT_NOW(a_ready_only_on_full, clk, arst_n, !in_ready, out_valid && !out_ready)

	// a stalled result holds
	`UCW_ASSERT_NEXT(a_result_holds, clk, arst_n, out_valid && !out_ready, out_valid && $stable(stop_request) && $stable(zone))

endmodule

bind ultrasonic_collision_warning_core ucw_checker u_ucw_checker (.*);

`default_nettype wire
